// ===== design/arx4h_pkg.sv =====
package arx4h_pkg;

  // Mixing constants
  localparam logic [63:0] PHI_K = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_A = 64'h85EBCA77C2B2AE3D;
  localparam logic [63:0] MIX_B = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_C = 64'h94D049BB133111EB;

  // Lane rotations
  localparam int unsigned ROT_ONE   = 11;
  localparam int unsigned ROT_TWO   = 17;
  localparam int unsigned ROT_THREE = 23;
  localparam int unsigned ROT_FOUR  = 57;

  // Finalizer shifts
  localparam int unsigned SH_MERGE = 29;
  localparam int unsigned SH_FIN_A = 31;
  localparam int unsigned SH_FIN_B = 37;
  localparam int unsigned SH_OUT   = 41;

  localparam logic [3:0] WORD_BYTES = 4'd8;

  // One queued work item
  typedef struct packed {
    logic        start;
    logic        last;
    logic [63:0] seed;
    logic [31:0] len;
    logic [63:0] word;
    logic [3:0]  nb;
  } op_t;

  // Rotate left by a fixed, nonzero amount
  function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned k);
    return (x << k) | (x >> (64 - k));
  endfunction

  // Xor-shift step of the finalizer
  function automatic logic [63:0] xs(input logic [63:0] x, input int unsigned k);
    return x ^ (x >> k);
  endfunction

  // Multiplier used to seed each lane
  function automatic logic [63:0] seed_mult(input logic [1:0] k);
    logic [63:0] m;
    unique case (k)
      2'd0: m = PHI_K;
      2'd1: m = MIX_A;
      2'd2: m = MIX_B;
      default: m = MIX_C;
    endcase
    return m;
  endfunction

endpackage

// ===== design/arx4h_mul.sv =====
// 64x64 -> low 64 bits, built from three 32x32 partial products, one per cycle
module arx4h_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] p
);

  logic [63:0] a_r, b_r;
  logic [63:0] prod_r, acc_r;
  logic [1:0]  cnt_r;
  logic        run_r, done_r;
  logic [31:0] op_x, op_y;

  // Select the partial product for this step
  always_comb begin
    case (cnt_r)
      2'd1: begin
        op_x = a_r[63:32];
        op_y = b_r[31:0];
      end
      2'd2: begin
        op_x = a_r[31:0];
        op_y = b_r[63:32];
      end
      default: begin
        op_x = a_r[31:0];
        op_y = b_r[31:0];
      end
    endcase
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= 2'd0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: product registered, accumulated the cycle after
  always_ff @(posedge clk) begin
    if (go) begin
      a_r <= a;
      b_r <= b;
    end
    if (run_r) begin
      prod_r <= op_x * op_y;
      case (cnt_r)
        2'd0: acc_r <= acc_r;
        2'd1: acc_r <= prod_r;
        default: acc_r <= acc_r + {prod_r[31:0], 32'd0};
      endcase
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

// ===== design/arx4h_fifo.sv =====
// Two-entry queue between front and back
module arx4h_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  arx4h_pkg::op_t  push_op,
  input  logic            pop,
  output arx4h_pkg::op_t  head,
  output logic            full,
  output logic            empty
);

  arx4h_pkg::op_t ent_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_op;
  end

  assign head  = ent_r[rd_ptr_r];
  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);

endmodule

// ===== design/arx4h_front.sv =====
// Front end: accepts items, drops those outside a message, trims the payload
module arx4h_front #(
  parameter int LENGTH_BITS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            in_start_req,
  input  logic [63:0]     in_seed,
  input  logic [31:0]     in_message_length,
  input  logic [63:0]     in_data_word,
  input  logic [3:0]      in_valid_bytes,
  input  logic            in_last,
  input  logic            q_full,
  output logic            q_push,
  output arx4h_pkg::op_t  q_op
);

  logic       active_r, active_nxt;
  logic       accept;
  logic [3:0] nb;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Message tracking: start opens, last closes
  always_comb begin
    active_nxt = active_r;
    if (accept) begin
      if (in_start_req || active_r) active_nxt = !in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) active_r <= 1'b0;
    else        active_r <= active_nxt;
  end

  assign q_push = accept && (in_start_req || active_r);

  // Clamp the byte count, zero unused bytes, trim the length
  assign nb = (in_valid_bytes > arx4h_pkg::WORD_BYTES) ? arx4h_pkg::WORD_BYTES
                                                        : in_valid_bytes;

  always_comb begin
    q_op.start = in_start_req;
    q_op.last  = in_last;
    q_op.seed  = in_seed;
    q_op.nb    = nb;
    for (int i = 0; i < 8; i++) begin
      q_op.word[8*i +: 8] = (4'(i) < nb) ? in_data_word[8*i +: 8] : 8'd0;
    end
    for (int i = 0; i < 32; i++) begin
      q_op.len[i] = (i < LENGTH_BITS) ? in_message_length[i] : 1'b0;
    end
  end

endmodule

// ===== design/arx4h_back.sv =====
// Back end: seeding, per-word absorb, finalizer, result register
module arx4h_back #(
  parameter int LENGTH_BITS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  arx4h_pkg::op_t  head,
  input  logic            q_empty,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [63:0]     out_hash_value,
  output logic            out_length_error
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_BASE   = 7'b0000010,
    S_SEED   = 7'b0000100,
    S_ABSORB = 7'b0001000,
    S_MERGE  = 7'b0010000,
    S_FIN    = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t         state_r, state_nxt;
  arx4h_pkg::op_t op_r, op_nxt;
  logic [63:0]    base_r, base_nxt;
  logic [63:0]    hash_r, hash_nxt;
  logic [1:0]     k_r, k_nxt;
  logic [63:0]    lane1_r, lane2_r, lane3_r, lane4_r;
  logic [63:0]    lane1_nxt, lane2_nxt, lane3_nxt, lane4_nxt;
  logic [LENGTH_BITS-1:0] stated_r, stated_nxt;
  logic [LENGTH_BITS:0]   bytes_r, bytes_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [63:0]    out_hash_r, out_hash_nxt;
  logic           out_err_r, out_err_nxt;

  logic           mul_go, mul_done;
  logic [63:0]    mul_a, mul_b, mul_p, merged;

  logic           ab_en;
  logic [63:0]    ab_word;
  logic [3:0]     ab_nb;
  logic           in_blk;
  logic [1:0]     sel;
  logic [LENGTH_BITS+1:0] sum;
  logic [LENGTH_BITS-3:0] idx, blk_words;

  arx4h_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (mul_go),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .p    (mul_p)
  );

  // Word routing by position within the stated length
  assign idx       = bytes_r[LENGTH_BITS:3];
  assign blk_words = (LENGTH_BITS-2)'({stated_r[LENGTH_BITS-1:5], 2'b00});
  assign in_blk    = idx < blk_words;
  assign sel       = in_blk ? bytes_r[4:3] : 2'd0;
  assign sum       = {1'b0, bytes_r} + (LENGTH_BITS+2)'(ab_nb);
  assign merged    = lane1_r ^ lane2_r ^ lane3_r ^ lane4_r;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    base_nxt      = base_r;
    hash_nxt      = hash_r;
    k_nxt         = k_r;
    stated_nxt    = stated_r;
    bytes_nxt     = bytes_r;
    lane1_nxt     = lane1_r;
    lane2_nxt     = lane2_r;
    lane3_nxt     = lane3_r;
    lane4_nxt     = lane4_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_hash_nxt  = out_hash_r;
    out_err_nxt   = out_err_r;
    q_pop         = 1'b0;
    mul_go        = 1'b0;
    mul_a         = 64'd0;
    mul_b         = 64'd0;
    ab_en         = 1'b0;
    ab_word       = head.word;
    ab_nb         = head.nb;

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (head.start) begin
            op_nxt     = head;
            stated_nxt = LENGTH_BITS'(head.len);
            bytes_nxt  = '0;
            mul_go     = 1'b1;
            mul_a      = 64'(head.len);
            mul_b      = arx4h_pkg::PHI_K;
            state_nxt  = S_BASE;
          end else begin
            ab_en = 1'b1;
            if (head.last) state_nxt = S_MERGE;
          end
        end
      end
      S_BASE: begin
        if (mul_done) begin
          base_nxt  = op_r.seed ^ mul_p;
          mul_go    = 1'b1;
          mul_a     = op_r.seed ^ mul_p;
          mul_b     = arx4h_pkg::seed_mult(2'd0);
          k_nxt     = 2'd0;
          state_nxt = S_SEED;
        end
      end
      S_SEED: begin
        if (mul_done) begin
          case (k_r)
            2'd0:    lane1_nxt = mul_p;
            2'd1:    lane2_nxt = mul_p;
            2'd2:    lane3_nxt = mul_p;
            default: lane4_nxt = mul_p;
          endcase
          if (k_r == 2'd3) begin
            state_nxt = S_ABSORB;
          end else begin
            mul_go = 1'b1;
            mul_a  = base_r;
            mul_b  = arx4h_pkg::seed_mult(k_r + 2'd1);
            k_nxt  = k_r + 2'd1;
          end
        end
      end
      S_ABSORB: begin
        ab_en     = 1'b1;
        ab_word   = op_r.word;
        ab_nb     = op_r.nb;
        state_nxt = op_r.last ? S_MERGE : S_IDLE;
      end
      S_MERGE: begin
        mul_go    = 1'b1;
        mul_a     = arx4h_pkg::xs(merged, arx4h_pkg::SH_MERGE);
        mul_b     = arx4h_pkg::MIX_A;
        k_nxt     = 2'd0;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (mul_done) begin
          if (k_r == 2'd0) begin
            mul_go = 1'b1;
            mul_a  = arx4h_pkg::xs(mul_p, arx4h_pkg::SH_FIN_A);
            mul_b  = arx4h_pkg::MIX_B;
            k_nxt  = 2'd1;
          end else if (k_r == 2'd1) begin
            mul_go = 1'b1;
            mul_a  = arx4h_pkg::xs(mul_p, arx4h_pkg::SH_FIN_B);
            mul_b  = arx4h_pkg::PHI_K;
            k_nxt  = 2'd2;
          end else begin
            hash_nxt  = arx4h_pkg::xs(mul_p, arx4h_pkg::SH_OUT);
            state_nxt = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = hash_r;
          out_err_nxt   = bytes_r != (LENGTH_BITS+1)'(stated_r);
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Absorb one word into the routed lane
    if (ab_en && (ab_nb != 4'd0)) begin
      case (sel)
        2'd0: lane1_nxt = arx4h_pkg::rotl((lane1_r ^ ab_word) + lane2_r, arx4h_pkg::ROT_ONE);
        2'd1: lane2_nxt = arx4h_pkg::rotl((lane2_r ^ ab_word) + lane3_r, arx4h_pkg::ROT_TWO);
        2'd2: lane3_nxt = arx4h_pkg::rotl((lane3_r ^ ab_word) + lane4_r,
                                          arx4h_pkg::ROT_THREE);
        default: lane4_nxt = arx4h_pkg::rotl((lane4_r ^ ab_word) + lane1_r,
                                             arx4h_pkg::ROT_FOUR);
      endcase
      // saturating byte count
      bytes_nxt = sum[LENGTH_BITS+1] ? '1 : sum[LENGTH_BITS:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    base_r     <= base_nxt;
    hash_r     <= hash_nxt;
    stated_r   <= stated_nxt;
    bytes_r    <= bytes_nxt;
    lane1_r    <= lane1_nxt;
    lane2_r    <= lane2_nxt;
    lane3_r    <= lane3_nxt;
    lane4_r    <= lane4_nxt;
    out_hash_r <= out_hash_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_hash_value   = out_hash_r;
  assign out_length_error = out_err_r;

endmodule

// ===== design/arx_four_lane_hash64.sv =====
// Plain message items: one per cycle while the back end is idle, absorbed as they
// leave the two-entry queue. Start item: five 64-bit multiplies on the shared
// 32x32 multiplier (length mix, then one per lane), plus the absorb step.
// Last item: after it leaves the queue, the merge and three finalizer multiplies
// form the hash; the back end idles again once the result register can take it.
// Reset: synchronous, active low; clears queue, message tracking, sequencer, output.
module arx_four_lane_hash64 #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_start_req,
  input  logic [63:0] in_seed,
  input  logic [31:0] in_message_length,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_valid_bytes,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_hash_value,
  output logic        out_length_error
);

  arx4h_pkg::op_t push_op, head;
  logic q_push, q_pop, q_full, q_empty;

  arx4h_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_start_req     (in_start_req),
    .in_seed          (in_seed),
    .in_message_length(in_message_length),
    .in_data_word     (in_data_word),
    .in_valid_bytes   (in_valid_bytes),
    .in_last          (in_last),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_op             (push_op)
  );

  arx4h_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .push_op(push_op),
    .pop    (q_pop),
    .head   (head),
    .full   (q_full),
    .empty  (q_empty)
  );

  arx4h_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hash_value  (out_hash_value),
    .out_length_error(out_length_error)
  );

`ifndef SYNTHESIS
  // queue never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue push while full");

  // queue never read while empty
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue pop while empty");

  // reset leaves no result pending
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule
